/* hw/rtl/u16u8_pkg.sv */
// Shared types, constants and the code point encoder for the UTF-16 to UTF-8 transcoder.
`default_nettype none

package u16u8_pkg;

	localparam logic [15:0] BYTE_LIMIT_RST  = 16'd1023;
	localparam int          MAX_BYTES       = 6;
	localparam int          QUEUE_DEPTH_DEF = 2;

	localparam logic [5:0]  HIGH_SURR_TAG   = 6'b110110;
	localparam logic [5:0]  LOW_SURR_TAG    = 6'b110111;
	localparam logic [20:0] SUPP_BASE       = 21'h10000;
	localparam logic [20:0] ONE_BYTE_TOP    = 21'h80;
	localparam logic [20:0] TWO_BYTE_TOP    = 21'h800;
	localparam logic [20:0] THREE_BYTE_TOP  = 21'h10000;
	localparam logic [7:0]  LEAD2           = 8'hc0;
	localparam logic [7:0]  LEAD3           = 8'he0;
	localparam logic [7:0]  LEAD4           = 8'hf0;
	localparam logic [7:0]  CONT            = 8'h80;

	typedef struct packed {
		logic [2:0]       len;
		logic [3:0][7:0]  b;
	} seq_t;

	// One classified item: the bytes it sends, with its end and truncation flags
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [2:0]                nbytes;
		logic                      last;
		logic                      trunc;
	} item_t;

	function automatic seq_t enc_cp(input logic [20:0] cp);
		seq_t s;
		s.b = '0;
		if (cp < ONE_BYTE_TOP) begin
			s.len  = 3'd1;
			s.b[0] = {1'b0, cp[6:0]};
		end else if (cp < TWO_BYTE_TOP) begin
			s.len  = 3'd2;
			s.b[0] = LEAD2 | {3'b000, cp[10:6]};
			s.b[1] = CONT | {2'b00, cp[5:0]};
		end else if (cp < THREE_BYTE_TOP) begin
			s.len  = 3'd3;
			s.b[0] = LEAD3 | {4'b0000, cp[15:12]};
			s.b[1] = CONT | {2'b00, cp[11:6]};
			s.b[2] = CONT | {2'b00, cp[5:0]};
		end else begin
			s.len  = 3'd4;
			s.b[0] = LEAD4 | {5'b00000, cp[20:18]};
			s.b[1] = CONT | {2'b00, cp[17:12]};
			s.b[2] = CONT | {2'b00, cp[11:6]};
			s.b[3] = CONT | {2'b00, cp[5:0]};
		end
		return s;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/u16u8_front.sv */
// Front end: accepts code units, pairs surrogates, applies the byte limit and builds queue items.
`default_nettype none

module u16u8_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [15:0]         cfg_data,
	input  wire logic                accept,
	input  wire logic [15:0]         code_unit,
	input  wire logic                last_unit,
	output logic                     push,
	output u16u8_pkg::item_t         push_item
);
	import u16u8_pkg::*;

	logic [15:0] byte_limit_q;
	logic [9:0]  pend_hi_q;
	logic        pend_vld_q;
	logic [15:0] bw_q;
	logic        stop_q;

	logic        hs, ls, hold, unit_step, have_a, have_b;
	logic        ok_a, ok_b, sent_a, sent_b, stop_a, stop_b, b_try, new_stop, hold_eff;
	seq_t        seq_pair, seq_high, seq_unit, seq_a;
	logic [2:0]  len_a, na, nb;
	logic [16:0] sum_a, sum_b;
	logic [2:0]  pos, off;

	assign hs = (code_unit[15:10] == HIGH_SURR_TAG);
	assign ls = (code_unit[15:10] == LOW_SURR_TAG);

	assign seq_pair = enc_cp(SUPP_BASE + {1'b0, pend_hi_q, code_unit[9:0]});
	assign seq_high = enc_cp({5'b00000, HIGH_SURR_TAG, pend_hi_q});
	assign seq_unit = enc_cp({5'b00000, code_unit});
	assign seq_a    = ls ? seq_pair : seq_high;

	assign have_a    = pend_vld_q & ~stop_q;
	assign unit_step = ~stop_q & ~(pend_vld_q & ls);
	assign hold      = unit_step & hs & ~last_unit;
	assign have_b    = unit_step & ~hold;

	assign len_a  = have_a ? seq_a.len : 3'd0;
	assign sum_a  = {1'b0, bw_q} + {14'd0, len_a};
	assign ok_a   = sum_a <= {1'b0, byte_limit_q};
	assign sent_a = have_a & ok_a;
	assign stop_a = have_a & ~ok_a;

	// A failed first sequence stops the string before the unit is looked at
	assign b_try  = have_b & ~stop_a;
	assign sum_b  = sum_a + {14'd0, seq_unit.len};
	assign ok_b   = sum_b <= {1'b0, byte_limit_q};
	assign sent_b = b_try & ok_b;
	assign stop_b = b_try & ~ok_b;

	assign new_stop = stop_q | stop_a | stop_b;
	assign hold_eff = hold & ~stop_a;

	assign na = sent_a ? seq_a.len : 3'd0;
	assign nb = sent_b ? seq_unit.len : 3'd0;

	always_comb begin
		push_item.nbytes = na + nb;
		push_item.last   = last_unit;
		push_item.trunc  = new_stop;
		pos = '0;
		off = '0;
		for (int i = 0; i < MAX_BYTES; i++) begin
			pos = 3'(i);
			off = pos - na;
			if (pos < na) begin
				push_item.bytes[i] = seq_a.b[pos[1:0]];
			end else begin
				push_item.bytes[i] = seq_unit.b[off[1:0]];
			end
		end
	end

	assign push = accept & ((push_item.nbytes != 3'd0) | last_unit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_limit_q <= BYTE_LIMIT_RST;
		end else if (cfg_we) begin
			byte_limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_hi_q  <= '0;
			pend_vld_q <= 1'b0;
			bw_q       <= '0;
			stop_q     <= 1'b0;
		end else if (accept) begin
			if (last_unit) begin
				pend_hi_q  <= '0;
				pend_vld_q <= 1'b0;
				bw_q       <= '0;
				stop_q     <= 1'b0;
			end else begin
				if (hold_eff) begin
					pend_hi_q <= code_unit[9:0];
				end
				pend_vld_q <= hold_eff;
				stop_q     <= new_stop;
				if (sent_b) begin
					bw_q <= sum_b[15:0];
				end else if (sent_a) begin
					bw_q <= sum_a[15:0];
				end
			end
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/u16u8_queue.sv */
// Small item queue between the front end and the byte emitter.
`default_nettype none

module u16u8_queue #(
	parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire u16u8_pkg::item_t    push_item,
	input  wire logic                pop,
	output u16u8_pkg::item_t         head_item,
	output logic                     full,
	output logic                     empty
);
	import u16u8_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t              mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push, do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign do_push   = push & ~full;
	assign do_pop    = pop & ~empty;
	assign head_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/u16u8_back.sv */
// Back end: walks one queued item byte by byte into the output register.
`default_nettype none

module u16u8_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire u16u8_pkg::item_t    head_item,
	input  wire logic                q_empty,
	output logic                     q_pop,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [7:0]               out_byte,
	output logic                     byte_valid,
	output logic                     last_of_item,
	output logic                     string_end,
	output logic                     truncated
);
	import u16u8_pkg::*;

	item_t       cur_q;
	logic        cur_vld_q;
	logic [2:0]  idx_q;
	logic        out_vld_q;
	logic [7:0]  byte_q;
	logic        bvld_q, loi_q, send_q, trunc_q;

	logic [2:0]  n_res;
	logic        is_last, slot_free, emit, has_data;

	// An item with no data bytes is a bare end marker: one result
	assign has_data  = (cur_q.nbytes != 3'd0);
	assign n_res     = has_data ? cur_q.nbytes : 3'd1;
	assign is_last   = (idx_q == n_res - 3'd1);
	assign slot_free = ~out_vld_q | ~out_stall;
	assign emit      = cur_vld_q & slot_free;
	assign q_pop     = ~q_empty & (~cur_vld_q | (emit & is_last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_vld_q <= 1'b0;
			idx_q     <= '0;
		end else if (q_pop) begin
			cur_vld_q <= 1'b1;
			idx_q     <= '0;
		end else if (emit & is_last) begin
			cur_vld_q <= 1'b0;
		end else if (emit) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= head_item;
		end
		if (emit) begin
			byte_q  <= has_data ? cur_q.bytes[idx_q] : 8'h00;
			bvld_q  <= has_data;
			loi_q   <= is_last;
			send_q  <= is_last & cur_q.last;
			trunc_q <= cur_q.trunc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	assign out_valid    = out_vld_q;
	assign out_byte     = byte_q;
	assign byte_valid   = bvld_q;
	assign last_of_item = loi_q;
	assign string_end   = send_q;
	assign truncated    = trunc_q;

endmodule

`default_nettype wire

/* hw/rtl/utf16le_to_utf8_transcoder_core.sv */
// UTF-16 to UTF-8 transcoder top level: front end, item queue and byte emitter.
//
// Input channel (in_valid / in_stall): one UTF-16 code unit per item, last_unit
// marks the final unit of a string. The front end takes one item per cycle
// while the queue has room.
// Output channel (out_valid / out_stall): one UTF-8 byte per item with its
// flags. The emitter sends one result per cycle while the receiver does not stall, so an item
// yields max(1, bytes sent) results: one for ASCII, up to six for a held high
// surrogate followed by a BMP unit. A non-final unit that sends nothing
// pushes no item and so never occupies the emitter; a held high surrogate waits for the next unit.
// Between input acceptance and the first result lie the queue entry, the current-item register and the output register.
// cfg_we / cfg_data write the byte limit; write it only while idle.
// Reset clears the surrogate hold, byte count, stop flag and queue, and sets
// the byte limit to 1023.
// When the receiver stalls, the output register holds; the queue fills and
// then in_stall rises until results drain.
`default_nettype none

module utf16le_to_utf8_transcoder_core #(
	parameter int QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic [15:0]   cfg_data,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic [15:0]   code_unit,
	input  wire logic          last_unit,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic [7:0]         out_byte,
	output logic               byte_valid,
	output logic               last_of_item,
	output logic               string_end,
	output logic               truncated
);
	import u16u8_pkg::*;

	logic   accept, push, pop, q_full, q_empty;
	item_t  push_item, head_item;

	assign in_stall = q_full;
	assign accept   = in_valid & ~in_stall;

	u16u8_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.code_unit (code_unit),
		.last_unit (last_unit),
		.push      (push),
		.push_item (push_item)
	);

	u16u8_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head_item (head_item),
		.full      (q_full),
		.empty     (q_empty)
	);

	u16u8_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_item    (head_item),
		.q_empty      (q_empty),
		.q_pop        (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.byte_valid   (byte_valid),
		.last_of_item (last_of_item),
		.string_end   (string_end),
		.truncated    (truncated)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("item pushed into a full queue");

	a_end_closes_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && string_end |-> last_of_item)
		else $error("string end without item end");

	a_bare_marker: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_valid |-> string_end && last_of_item && out_byte == 8'h00)
		else $error("bare marker outside end of string");

	a_pop_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("pop from an empty queue");

endmodule

`default_nettype wire

/* test/utf16le_to_utf8_transcoder_core_test.sv */
// Self-checking testbench for the UTF-16 to UTF-8 transcoder core.
`timescale 1ns / 1ps

module utf16le_to_utf8_transcoder_core_test;

	localparam int IDLE_PCT    = 34;
	localparam int SETTLE      = 8;
	localparam int HOLD_CYCLES = 80;
	localparam int STALL_LIMIT = 1000;

	typedef struct packed {
		logic [7:0] data;
		logic       dvalid;
		logic       item_end;
		logic       str_end;
		logic       trunc;
	} utf8_res_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [15:0] code_unit;
	logic        last_unit;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  out_byte;
	logic        byte_valid;
	logic        last_of_item;
	logic        string_end;
	logic        truncated;

	// transcoder state as the block should hold it
	logic [15:0] limit_m;
	logic [9:0]  held_hi;
	logic        held_vld;
	logic [15:0] sent_cnt;
	logic        halted;

	utf8_res_t   item_bytes[$];
	utf8_res_t   utf8_expected[$];
	utf8_res_t   seen_res;
	utf8_res_t   want_res;

	int          errors;
	int          idle_cycles;
	int          units_sent;
	logic        quiet;
	logic        hold_off_req;

	utf16le_to_utf8_transcoder_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.code_unit    (code_unit),
		.last_unit    (last_unit),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.byte_valid   (byte_valid),
		.last_of_item (last_of_item),
		.string_end   (string_end),
		.truncated    (truncated)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic void push_byte(logic [7:0] b);
		item_bytes.push_back('{b, 1'b1, 1'b0, 1'b0, 1'b0});
	endfunction

	// A sequence goes out whole or not at all
	function automatic void emit_cp(logic [20:0] cp);
		int n;
		if (halted)
			return;
		n = (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
		if (32'(sent_cnt) + n > 32'(limit_m)) begin
			halted = 1'b1;
			held_vld = 1'b0;
			return;
		end
		case (n)
			1: push_byte(cp[7:0]);
			2: begin
				push_byte(8'hc0 | {3'b000, cp[10:6]});
				push_byte(8'h80 | {2'b00, cp[5:0]});
			end
			3: begin
				push_byte(8'he0 | {4'b0000, cp[15:12]});
				push_byte(8'h80 | {2'b00, cp[11:6]});
				push_byte(8'h80 | {2'b00, cp[5:0]});
			end
			default: begin
				push_byte(8'hf0 | {5'b00000, cp[20:18]});
				push_byte(8'h80 | {2'b00, cp[17:12]});
				push_byte(8'h80 | {2'b00, cp[11:6]});
				push_byte(8'h80 | {2'b00, cp[5:0]});
			end
		endcase
		sent_cnt = sent_cnt + 16'(n);
	endfunction

	function automatic void take_unit(logic [15:0] cu, logic last);
		if (halted)
			return;
		if (cu >= 16'hd800 && cu <= 16'hdbff && !last) begin
			held_hi = cu[9:0];
			held_vld = 1'b1;
		end else
			emit_cp({5'b0, cu});
	endfunction

	function automatic void predict_unit(logic [15:0] cu, logic last);
		item_bytes.delete();
		if (halted)
			held_vld = 1'b0;
		else if (held_vld) begin
			held_vld = 1'b0;
			if (cu >= 16'hdc00 && cu <= 16'hdfff)
				emit_cp(21'h10000 + {1'b0, held_hi, cu[9:0]});
			else begin
				emit_cp({5'b0, 6'b110110, held_hi});
				take_unit(cu, last);
			end
		end else
			take_unit(cu, last);
		if (last && item_bytes.size() == 0)
			item_bytes.push_back('{8'h00, 1'b0, 1'b0, 1'b0, 1'b0});
		foreach (item_bytes[k])
			item_bytes[k].trunc = halted;
		if (item_bytes.size() > 0) begin
			item_bytes[item_bytes.size() - 1].item_end = 1'b1;
			item_bytes[item_bytes.size() - 1].str_end = last;
		end
		foreach (item_bytes[k])
			utf8_expected.push_back(item_bytes[k]);
		if (last) begin
			held_vld = 1'b0;
			held_hi = '0;
			sent_cnt = '0;
			halted = 1'b0;
		end
	endfunction

	task automatic send_unit(logic [15:0] cu, logic last);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		code_unit <= cu;
		last_unit <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_unit(cu, last);
		units_sent++;
	endtask

	// Wait out results, then the items that produce none
	task automatic settle();
		in_valid <= 1'b0;
		while (utf8_expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_limit(logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		limit_m = v;
	endtask

	task automatic send_text(int len);
		int i;
		int kind;
		logic [15:0] u;
		i = 0;
		while (i < len) begin
			kind = $urandom_range(9);
			if ((kind == 6 || kind == 7) && i + 1 < len) begin
				send_unit(16'hd800 | 16'($urandom_range(1023)), 1'b0);
				send_unit(16'hdc00 | 16'($urandom_range(1023)), i + 2 == len);
				i += 2;
			end else begin
				case (kind)
					0, 1, 2: u = 16'($urandom_range(127));
					3:       u = 16'($urandom_range(16'h80, 16'h7ff));
					4, 5:    u = $urandom_range(1) ? 16'($urandom_range(16'h800, 16'hd7ff))
						: 16'($urandom_range(16'he000, 16'hffff));
					8:       u = 16'($urandom_range(16'hd800, 16'hdfff));
					default: u = 16'($urandom);
				endcase
				send_unit(u, i + 1 == len);
				i++;
			end
		end
	endtask

	// Every width class, pairs, lone surrogates of both kinds, held highs at string end
	task automatic test_encoding_forms();
		send_unit(16'h0041, 1'b0);
		send_unit(16'h007f, 1'b0);
		send_unit(16'h0080, 1'b0);
		send_unit(16'h07ff, 1'b0);
		send_unit(16'h0800, 1'b0);
		send_unit(16'hffff, 1'b0);
		send_unit(16'h0000, 1'b1);
		send_unit(16'hd800, 1'b0);
		send_unit(16'hdc00, 1'b0);
		send_unit(16'hdbff, 1'b0);
		send_unit(16'hdfff, 1'b1);
		send_unit(16'hdbff, 1'b0);
		send_unit(16'h0041, 1'b0);
		send_unit(16'hdc00, 1'b0);
		send_unit(16'hd800, 1'b0);
		send_unit(16'hdbff, 1'b0);
		send_unit(16'hdc00, 1'b0);
		send_unit(16'hd800, 1'b1);
		send_unit(16'h0061, 1'b1);
		send_unit(16'hd801, 1'b0);
		send_unit(16'h0042, 1'b1);
		settle();
	endtask

	task automatic test_byte_limit();
		// zero limit: the first unit stops output, end comes as a bare marker
		write_limit(16'h0000);
		send_unit(16'h0041, 1'b0);
		send_unit(16'hd800, 1'b0);
		send_unit(16'hdc00, 1'b1);
		send_unit(16'hd800, 1'b0);
		send_unit(16'h0041, 1'b1);
		settle();
		write_limit(16'd3);
		send_unit(16'h0041, 1'b0);
		send_unit(16'h0041, 1'b0);
		send_unit(16'h0800, 1'b0);
		send_unit(16'h0041, 1'b1);
		send_unit(16'h0800, 1'b1);
		settle();
		write_limit(16'd4);
		send_unit(16'hd83d, 1'b0);
		send_unit(16'hde00, 1'b1);
		send_unit(16'h0041, 1'b0);
		send_unit(16'hd83d, 1'b0);
		send_unit(16'hde00, 1'b0);
		send_unit(16'h0042, 1'b1);
		settle();
		write_limit(16'hffff);
		send_text(6);
		settle();
	endtask

	task automatic test_output_hold();
		hold_off_req = 1'b1;
		for (int k = 0; k < 14; k++)
			send_unit(16'($urandom_range(16'h800, 16'hd7ff)), k == 13);
		settle();
	endtask

	task automatic test_random_text();
		logic [15:0] lim;
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0:       lim = 16'hffff;
				1:       lim = 16'($urandom_range(12));
				2:       lim = 16'($urandom);
				3:       lim = 16'($urandom_range(4, 24));
				default: lim = 16'd1023;
			endcase
			quiet = (phase == 2);
			write_limit(lim);
			repeat (3) send_text($urandom_range(1, 8));
			settle();
		end
		quiet = 1'b0;
	endtask

	// Receiver: random stalls, or a long hold-off on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
				out_stall <= 1'b0;
			end else
				out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			seen_res = '{out_byte, byte_valid, last_of_item, string_end, truncated};
			if (utf8_expected.size() == 0) begin
				$display("%0t: unexpected byte=%h valid=%b item_end=%b str_end=%b trunc=%b",
					$time, out_byte, byte_valid, last_of_item, string_end, truncated);
				errors++;
			end else begin
				want_res = utf8_expected.pop_front();
				if (seen_res !== want_res) begin
					$display("%0t: expected byte=%h valid=%b item_end=%b str_end=%b trunc=%b",
						$time, want_res.data, want_res.dvalid, want_res.item_end,
						want_res.str_end, want_res.trunc);
					$display("%0t: actual   byte=%h valid=%b item_end=%b str_end=%b trunc=%b",
						$time, seen_res.data, seen_res.dvalid, seen_res.item_end,
						seen_res.str_end, seen_res.trunc);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, idle_cycles);
				$display("CHECKS FAILED");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		code_unit = '0;
		last_unit = 1'b0;
		errors = 0;
		idle_cycles = 0;
		units_sent = 0;
		quiet = 1'b0;
		hold_off_req = 1'b0;
		limit_m = 16'd1023;
		held_hi = '0;
		held_vld = 1'b0;
		sent_cnt = '0;
		halted = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_encoding_forms();
		test_byte_limit();
		test_output_hold();
		test_random_text();
		settle();
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
